// File: rtl/core/blc_pkg.sv
// Shared types and constants for the block cache LRU controller.
// Defines the per-cell scan token and the line update command; no dependencies.
`default_nettype none

package blc_pkg;

    localparam int LINES      = 128;
    localparam int IDX_W      = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int TAG_W      = 30;
    localparam int AGE_W      = 32;
    localparam int BLK_W      = 32;
    localparam int OFF_W      = 2;
    localparam int LINE_IDX_W = 7;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [TAG_W-1:0] tag_t;
    typedef logic [AGE_W-1:0] age_t;

    // Search state that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic active;
        logic found;
        idx_t hit_idx;
        age_t best_age;
        idx_t best_idx;
        logic best_wb;
        tag_t best_tag;
    } token_t;

    // Line update broadcast to all cells when an access commits.
    typedef struct packed {
        logic en;
        idx_t index;
        logic hit;
        logic write;
        tag_t tag;
        age_t age;
    } update_t;

endpackage

`default_nettype wire

// File: rtl/core/blc_if.sv
// Valid/ready channel interfaces for the block cache LRU controller.
// Depends on blc_pkg for field widths.
`default_nettype none

interface blc_req_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [blc_pkg::BLK_W-1:0]  block_number;

    modport source (output valid, op, block_number, input ready);
    modport sink   (input valid, op, block_number, output ready);
endinterface

interface blc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [blc_pkg::LINE_IDX_W-1:0] line_index;
    logic [blc_pkg::OFF_W-1:0]      block_offset;
    logic                           writeback;
    logic [blc_pkg::TAG_W-1:0]      victim_tag;
    logic                           fill;
    logic [blc_pkg::TAG_W-1:0]      fill_tag;

    modport source (output valid, hit, line_index, block_offset, writeback, victim_tag,
                    fill, fill_tag, input ready);
    modport sink   (input valid, hit, line_index, block_offset, writeback, victim_tag,
                    fill, fill_tag, output ready);
endinterface

`default_nettype wire

// File: rtl/core/block_cache_lru_controller_top.sv
// A request transfer is registered in start_reg; the search token then steps through the
// line cells, one cell per cycle, into fin_reg, and the result is registered when the access commits.
// One access is in flight at a time; a finished result may wait in the output register
// while the next request is taken. Reset (rst_n, asynchronous) marks all lines invalid
// and clean with zero tag and age, and clears the use counter.
// Depends on blc_pkg, blc_if and blc_cell.
`default_nettype none

module block_cache_lru_controller_top (
    input  wire               clk,
    input  wire               rst_n,
    blc_req_if.sink           req,
    blc_rsp_if.source         rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic                             start_reg;
    logic                             op_reg;
    blc_pkg::tag_t                    req_tag_reg;
    logic [blc_pkg::OFF_W-1:0]        off_reg;
    blc_pkg::age_t                    counter_reg;
    blc_pkg::token_t                  fin_reg;

    logic                             rsp_valid_reg;
    logic                             hit_reg;
    logic [blc_pkg::LINE_IDX_W-1:0]   line_index_reg;
    logic [blc_pkg::OFF_W-1:0]        block_offset_reg;
    logic                             writeback_reg;
    blc_pkg::tag_t                    victim_tag_reg;
    logic                             fill_reg;
    blc_pkg::tag_t                    fill_tag_reg;

    blc_pkg::token_t                  tok [blc_pkg::LINES+1];
    blc_pkg::update_t                 upd;
    blc_pkg::idx_t                    sel;
    logic                             req_xfer;
    logic                             commit;
    logic                             last_done;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign last_done = tok[blc_pkg::LINES].active;
    assign commit    = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);
    assign sel       = fin_reg.found ? fin_reg.hit_idx : fin_reg.best_idx;

    always_comb
    begin
        tok[0]        = '0;
        tok[0].active = start_reg;
    end

    always_comb
    begin
        upd.en    = commit;
        upd.index = sel;
        upd.hit   = fin_reg.found;
        upd.write = op_reg;
        upd.tag   = req_tag_reg;
        upd.age   = counter_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < blc_pkg::LINES; gi++)
        begin : g_cell
            blc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .my_index (blc_pkg::idx_t'(gi)),
                .req_tag  (req_tag_reg),
                .upd      (upd),
                .tok_in   (tok[gi]),
                .tok_out  (tok[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            counter_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= req_xfer;
            if (commit)
            begin
                counter_reg   <= counter_reg + blc_pkg::age_t'(1);
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_reg      <= req.op;
            req_tag_reg <= req.block_number[blc_pkg::BLK_W-1:blc_pkg::OFF_W];
            off_reg     <= req.block_number[blc_pkg::OFF_W-1:0];
        end
        if ((state_reg == ST_SCAN) && last_done)
        begin
            fin_reg <= tok[blc_pkg::LINES];
        end
        if (commit)
        begin
            hit_reg          <= fin_reg.found;
            line_index_reg   <= blc_pkg::LINE_IDX_W'(sel);
            block_offset_reg <= off_reg;
            writeback_reg    <= !fin_reg.found && fin_reg.best_wb;
            victim_tag_reg   <= (!fin_reg.found && fin_reg.best_wb) ? fin_reg.best_tag : '0;
            fill_reg         <= !fin_reg.found;
            fill_tag_reg     <= fin_reg.found ? '0 : req_tag_reg;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.hit          = hit_reg;
    assign rsp.line_index   = line_index_reg;
    assign rsp.block_offset = block_offset_reg;
    assign rsp.writeback    = writeback_reg;
    assign rsp.victim_tag   = victim_tag_reg;
    assign rsp.fill         = fill_reg;
    assign rsp.fill_tag     = fill_tag_reg;

    // A result only appears after an access commits out of the done state.
    a_rsp_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a commit");

    // Hit and fill are mutually exclusive and one is always set.
    a_hit_xor_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (hit_reg != fill_reg))
        else $error("hit and fill disagree");

    // Write-back is only reported on a miss.
    a_wb_miss_only: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && writeback_reg) |-> !hit_reg)
        else $error("write-back reported on a hit");

    // The search token leaves the row only while a scan is running.
    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        last_done |-> (state_reg == ST_SCAN))
        else $error("search token completed outside a scan");

    // Cells are updated only once per access, never while a scan is in flight.
    a_commit_idle_row: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (state_reg == ST_IDLE))
        else $error("commit did not return to idle");

endmodule

`default_nettype wire

// File: rtl/core/blc_cell.sv
// One cache line cell: holds tag, valid, dirty and age, and advances the search token.
// Depends on blc_pkg for the token and update types.
`default_nettype none

module blc_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  blc_pkg::idx_t       my_index,
    input  blc_pkg::tag_t       req_tag,
    input  blc_pkg::update_t    upd,
    input  blc_pkg::token_t     tok_in,
    output blc_pkg::token_t     tok_out
);

    blc_pkg::tag_t   tag_reg;
    logic            valid_reg;
    logic            dirty_reg;
    blc_pkg::age_t   age_reg;
    blc_pkg::token_t tok_reg;
    blc_pkg::token_t tok_next;
    logic            upd_sel;

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.found && valid_reg && (tag_reg == req_tag))
        begin
            tok_next.found   = 1'b1;
            tok_next.hit_idx = my_index;
        end
        // The first cell seeds the minimum; later cells replace it only when strictly older.
        if ((my_index == blc_pkg::idx_t'(0)) || (age_reg < tok_in.best_age))
        begin
            tok_next.best_age = age_reg;
            tok_next.best_idx = my_index;
            tok_next.best_wb  = valid_reg && dirty_reg;
            tok_next.best_tag = tag_reg;
        end
    end

    assign upd_sel = upd.en && (upd.index == my_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= '0;
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            age_reg   <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (upd_sel)
            begin
                age_reg <= upd.age;
                if (upd.hit)
                begin
                    if (upd.write == blc_pkg::OP_WRITE)
                    begin
                        dirty_reg <= 1'b1;
                    end
                end
                else
                begin
                    tag_reg   <= upd.tag;
                    valid_reg <= 1'b1;
                    dirty_reg <= (upd.write == blc_pkg::OP_WRITE);
                end
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// File: verif/blc_access_checker.sv
// Checker for the block cache LRU controller: watches the request and result channels,
// predicts each access with its own line table and compares every result field.
// Depends on blc_pkg and the blc_req_if / blc_rsp_if interfaces.
`timescale 1ns / 1ps

module blc_access_checker (
    input  wire   clk,
    input  wire   rst_n,
    blc_req_if    req,
    blc_rsp_if    rsp,
    output int    errors,
    output int    pending
);
    import blc_pkg::*;

    typedef struct packed {
        logic                  hit;
        logic [LINE_IDX_W-1:0] line_index;
        logic [OFF_W-1:0]      block_offset;
        logic                  writeback;
        tag_t                  victim_tag;
        logic                  fill;
        tag_t                  fill_tag;
    } access_result_t;

    tag_t           line_tag   [LINES];
    logic           line_valid [LINES];
    logic           line_dirty [LINES];
    age_t           line_age   [LINES];
    age_t           use_count;
    access_result_t lookup_results_q[$];
    access_result_t want;
    int             error_count;
    int             result_count;

    assign errors  = error_count;
    assign pending = lookup_results_q.size();

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH result %0d: %s", $realtime, result_count, msg);
        error_count++;
    endtask

    // Updates the line table as the block would and returns the result it must give.
    function automatic access_result_t predict_access(input logic op,
                                                      input logic [BLK_W-1:0] blk);
        access_result_t r;
        tag_t           tag;
        age_t           oldest;
        int             sel;
        logic           found;
        r     = '0;
        tag   = blk[BLK_W-1:OFF_W];
        found = 1'b0;
        sel   = 0;
        for (int n = 0; n < LINES; n++)
        begin
            if (!found && line_valid[n] && line_tag[n] == tag)
            begin
                found = 1'b1;
                sel   = n;
            end
        end
        if (found)
        begin
            line_age[sel] = use_count;
            if (op == OP_WRITE)
                line_dirty[sel] = 1'b1;
        end
        else
        begin
            // Only ages count here; an invalid line has no priority over a valid one.
            oldest = line_age[0];
            for (int n = 1; n < LINES; n++)
            begin
                if (line_age[n] < oldest)
                begin
                    oldest = line_age[n];
                    sel    = n;
                end
            end
            if (line_valid[sel] && line_dirty[sel])
            begin
                r.writeback  = 1'b1;
                r.victim_tag = line_tag[sel];
            end
            line_tag[sel]   = tag;
            line_valid[sel] = 1'b1;
            line_dirty[sel] = (op == OP_WRITE);
            line_age[sel]   = use_count;
            r.fill          = 1'b1;
            r.fill_tag      = tag;
        end
        use_count      = use_count + 1'b1;
        r.hit          = found;
        r.line_index   = LINE_IDX_W'(sel);
        r.block_offset = blk[OFF_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < LINES; n++)
            begin
                line_tag[n]   = '0;
                line_valid[n] = 1'b0;
                line_dirty[n] = 1'b0;
                line_age[n]   = '0;
            end
            use_count = '0;
            lookup_results_q.delete();
        end
        else
        begin
            // A result can never belong to the request taken at the same edge.
            if (rsp.valid && rsp.ready)
            begin
                if (lookup_results_q.size() == 0)
                    report_mismatch("result transfer with no access outstanding");
                else
                begin
                    want = lookup_results_q.pop_front();
                    if (rsp.hit !== want.hit)
                        report_mismatch($sformatf("hit got %0h expected %0h",
                                                  rsp.hit, want.hit));
                    if (rsp.line_index !== want.line_index)
                        report_mismatch($sformatf("line_index got %0d expected %0d",
                                                  rsp.line_index, want.line_index));
                    if (rsp.block_offset !== want.block_offset)
                        report_mismatch($sformatf("block_offset got %0d expected %0d",
                                                  rsp.block_offset, want.block_offset));
                    if (rsp.writeback !== want.writeback)
                        report_mismatch($sformatf("writeback got %0h expected %0h",
                                                  rsp.writeback, want.writeback));
                    if (rsp.victim_tag !== want.victim_tag)
                        report_mismatch($sformatf("victim_tag got %0h expected %0h",
                                                  rsp.victim_tag, want.victim_tag));
                    if (rsp.fill !== want.fill)
                        report_mismatch($sformatf("fill got %0h expected %0h",
                                                  rsp.fill, want.fill));
                    if (rsp.fill_tag !== want.fill_tag)
                        report_mismatch($sformatf("fill_tag got %0h expected %0h",
                                                  rsp.fill_tag, want.fill_tag));
                end
                result_count++;
            end
            if (req.valid && req.ready)
                lookup_results_q.push_back(predict_access(req.op, req.block_number));
        end
    end

    initial
    begin
        error_count  = 0;
        result_count = 0;
    end
endmodule

// File: verif/block_cache_lru_controller_top_tb.sv
// Top of the block cache LRU controller testbench: clock, reset, access stimulus and
// result back-pressure, with the verdict taken from blc_access_checker.
// Depends on blc_pkg, blc_if, blc_access_checker and the block itself.
`timescale 1ns / 1ps

module block_cache_lru_controller_top_tb;
    import blc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int POOL_SIZE   = 300;

    logic clk = 1'b0;
    logic rst_n;
    logic no_idle = 1'b0;
    int   errors;
    int   pending;
    int   cycle_count = 0;
    tag_t tag_pool [POOL_SIZE];

    blc_req_if req_ch();
    blc_rsp_if rsp_ch();

    block_cache_lru_controller_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    blc_access_checker access_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Offers one access and returns at the edge where its transfer happens.
    task automatic send_access(input logic op, input logic [BLK_W-1:0] blk);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.block_number <= blk;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Working sets of different sizes give mostly hits, LRU churn or thrashing.
    task automatic run_phase(input int count, input int working_set);
        logic [BLK_W-1:0] blk;
        logic             op;
        int               pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                blk = $urandom;
            else if (pick < 25)
                blk = {tag_pool[$urandom_range(0, 7)], OFF_W'($urandom)};
            else
                blk = {tag_pool[$urandom_range(0, working_set - 1)], OFF_W'($urandom)};
            op = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
            send_access(op, blk);
        end
    endtask

    // The result side holds ready low for a drawn number of cycles once a result is
    // offered, so results really wait in the output register.
    initial
    begin
        int gap;
        rsp_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                @(posedge clk);
                while (!rsp_ch.valid)
                    @(posedge clk);
                repeat (gap - 1) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_READ;
        req_ch.block_number = '0;
        for (int k = 0; k < POOL_SIZE; k++)
            tag_pool[k] = TAG_W'($urandom);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Tag zero must miss after reset even though every stored tag is zero.
        send_access(OP_READ,  32'h0000_0000);
        send_access(OP_READ,  32'h0000_0000);
        send_access(OP_WRITE, 32'h0000_0001);
        send_access(OP_READ,  32'h0000_0004);
        send_access(OP_WRITE, 32'hFFFF_FFFF);
        send_access(OP_READ,  32'hFFFF_FFFC);
        send_access(OP_WRITE, 32'h5555_5555);
        send_access(OP_WRITE, 32'hAAAA_AAAA);
        send_access(OP_READ,  32'h8000_0000);
        send_access(OP_WRITE, 32'h7FFF_FFFF);
        send_access(OP_READ,  32'h0000_0002);
        send_access(OP_WRITE, 32'h0000_0003);
        // Write misses to new tags fill still-invalid lines and mark them dirty; no write-back occurs yet.
        for (int k = 0; k < 8; k++)
            send_access(OP_WRITE, 32'h0000_1000 + 32'(k * 4));
        send_access(OP_READ,  32'h0000_1000);

        run_phase(400, 40);
        no_idle = 1'b1;
        run_phase(150, 120);
        no_idle = 1'b0;
        run_phase(400, 130);
        run_phase(400, POOL_SIZE);
        run_phase(350, 140);
        req_ch.valid <= 1'b0;

        // The wait lets the checker record the last transfer before the drain check.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LINES + 4) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
